/* rtl/siab_pkg.sv */
`timescale 1ns / 1ps

package siab_pkg;

    // Field widths of one word.
    localparam int FIELD_W = 17;
    localparam int TEMP_W  = 16;
    localparam int IDX_W   = 2;

    // Register indexes.
    localparam logic [IDX_W-1:0] CFG_BARE_ICE_ALBEDO    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SNOW_ALBEDO        = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ICE_TRANSMISSIVITY = 2'd2;

    // Reset values, Q1.16.
    localparam logic [FIELD_W-1:0] RST_BARE_ICE_ALBEDO    = 17'd35258;
    localparam logic [FIELD_W-1:0] RST_SNOW_ALBEDO        = 17'd54107;
    localparam logic [FIELD_W-1:0] RST_ICE_TRANSMISSIVITY = 17'd11141;

    // Snow fraction divider: 2^32*d / (2^16*d + 200*c).
    localparam int DEN_W  = 34;
    localparam int REM_W  = 49;
    localparam int QUO_W  = 16;
    localparam int FRAC_W = 17;
    localparam logic [DEN_W-1:0] CONC_SCALE = 34'd200;

    // Warm-excess drops. Division by 5 and by 125 is done by reciprocal multiply.
    localparam int YICE_W  = 23;
    localparam int YSNOW_W = 27;
    localparam int DROP_W  = 21;
    localparam logic [YICE_W-1:0]  ICE_SLOPE      = 23'd96;
    localparam logic [YICE_W-1:0]  ICE_BIAS       = 23'd2;
    localparam logic [YSNOW_W-1:0] SNOW_SLOPE     = 27'd3968;
    localparam logic [YSNOW_W-1:0] SNOW_BIAS      = 27'd62;
    localparam int                 ICE_RECIP_W    = 23;
    localparam int                 SNOW_RECIP_W   = 28;
    localparam logic [ICE_RECIP_W-1:0]  ICE_RECIP  = 23'd6710887;
    localparam logic [SNOW_RECIP_W-1:0] SNOW_RECIP = 28'd137438954;
    localparam int ICE_PROD_W   = YICE_W + ICE_RECIP_W;
    localparam int SNOW_PROD_W  = YSNOW_W + SNOW_RECIP_W;
    localparam int ICE_SHIFT    = 25;
    localparam int SNOW_SHIFT   = 34;

    // Blend arithmetic.
    localparam int ALBT_W  = 22;
    localparam int DIFF_W  = 23;
    localparam int BPROD_W = DIFF_W + FRAC_W + 1;
    localparam int PPROD_W = 2 * FIELD_W;
    localparam int SUM_W   = 42;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

    // Pipeline stage numbering.
    localparam int STG_IN     = 0;
    localparam int STG_PREP   = 1;
    localparam int DIV_FIRST  = 2;
    localparam int DIV_LAST   = DIV_FIRST + QUO_W - 1;
    localparam int STG_ALBT   = DIV_FIRST + 1;
    localparam int STG_ROUND  = DIV_LAST + 1;
    localparam int STG_MUL    = DIV_LAST + 2;
    localparam int STG_OUT    = DIV_LAST + 3;
    localparam int NUM_STG    = STG_OUT + 1;

    typedef struct packed {
        logic             zero;
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } siab_div_t;

endpackage

/* rtl/sea_ice_albedo_blend_core.sv */
`timescale 1ns / 1ps

// Sea ice surface albedo, blended with its snow cover, one grid cell per word.
// Input channel: cell_valid / cell_stall carry ice_concentration, snow_depth and
// surface_temp. A word is taken at a clock edge with cell_valid high and
// cell_stall low. Output channel: result_valid / result_stall carry albedo and
// penetrating_sw, one result word for each input word, in order.
// An accepted word passes the input, preparation, divider, rounding, multiply
// and output stages in order. Throughput is one word per cycle while
// result_stall is low; the snow fraction divider resolves one quotient bit per
// pipeline stage over sixteen stages. When result_stall is high the pipeline
// holds its last full stage and keeps filling empty stages behind it, so
// cell_stall rises only once every stage is occupied. No word is lost or repeated.
// The configuration registers are written through cfg_we / cfg_index /
// cfg_data, by the user only while the block is idle; the block does not
// enforce this. Indexes beyond the list are ignored. Reset empties the
// pipeline and loads the cold albedo and transmissivity defaults.
module sea_ice_albedo_blend_core
    import siab_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [FIELD_W-1:0]        cfg_data,
    input  logic                      cell_valid,
    output logic                      cell_stall,
    input  logic [FIELD_W-1:0]        ice_concentration,
    input  logic [FIELD_W-1:0]        snow_depth,
    input  logic signed [TEMP_W-1:0]  surface_temp,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [FIELD_W-1:0]        albedo,
    output logic [FIELD_W-1:0]        penetrating_sw
);

    logic [FIELD_W-1:0] bare_ice_albedo_reg;
    logic [FIELD_W-1:0] snow_albedo_reg;
    logic [FIELD_W-1:0] ice_transmissivity_reg;

    logic [NUM_STG-1:0] valid_reg;
    logic [NUM_STG:0]   en;

    // Input stage.
    logic [FIELD_W-1:0]       conc_reg;
    logic [FIELD_W-1:0]       depth_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    // Preparation stage.
    logic signed [TEMP_W:0]   temp_exc;
    logic [TEMP_W-1:0]        warm;
    logic [YICE_W-1:0]        y_ice_next;
    logic [YICE_W-1:0]        y_ice_reg;
    logic [YSNOW_W-1:0]       y_snow_next;
    logic [YSNOW_W-1:0]       y_snow_reg;

    // Divider stages.
    siab_div_t div_next [STG_PREP:DIV_LAST];
    siab_div_t div_reg  [STG_PREP:DIV_LAST];

    // Temperature branch.
    logic [ICE_PROD_W-1:0]    ice_prod;
    logic [SNOW_PROD_W-1:0]   snow_prod;
    logic [DROP_W-1:0]        ice_drop_reg;
    logic [DROP_W-1:0]        snow_drop_reg;
    logic signed [ALBT_W-1:0] ice_t_next;
    logic signed [ALBT_W-1:0] snow_t_next;
    logic signed [ALBT_W-1:0] ice_t_reg  [STG_ALBT:DIV_LAST];
    logic signed [ALBT_W-1:0] snow_t_reg [STG_ALBT:DIV_LAST];

    // Rounding stage.
    logic                     round_up;
    logic [FRAC_W-1:0]        frac_next;
    logic [FRAC_W-1:0]        frac_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ALBT_W-1:0] ice_rnd_reg;

    // Multiply stage.
    logic signed [BPROD_W-1:0] blend_prod_next;
    logic signed [BPROD_W-1:0] blend_prod_reg;
    logic [PPROD_W-1:0]        pen_prod_next;
    logic [PPROD_W-1:0]        pen_prod_reg;
    logic signed [ALBT_W-1:0]  ice_mul_reg;

    // Output stage.
    logic signed [SUM_W-1:0]  blend_sum;
    logic [PPROD_W-1:0]       pen_sum;
    logic [FIELD_W-1:0]       albedo_next;
    logic [FIELD_W-1:0]       albedo_reg;
    logic [FIELD_W-1:0]       pen_next;
    logic [FIELD_W-1:0]       pen_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bare_ice_albedo_reg    <= RST_BARE_ICE_ALBEDO;
            snow_albedo_reg        <= RST_SNOW_ALBEDO;
            ice_transmissivity_reg <= RST_ICE_TRANSMISSIVITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BARE_ICE_ALBEDO:    bare_ice_albedo_reg    <= cfg_data;
                CFG_SNOW_ALBEDO:        snow_albedo_reg        <= cfg_data;
                CFG_ICE_TRANSMISSIVITY: ice_transmissivity_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or the next one loads.
    // ------------------------------------------------------------------
    assign en[NUM_STG] = !result_stall;

    for (genvar k = 0; k < NUM_STG; k++)
    begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    assign cell_stall   = !en[STG_IN];
    assign result_valid = valid_reg[STG_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[STG_IN])
            begin
                valid_reg[STG_IN] <= cell_valid;
            end
            for (int k = 1; k < NUM_STG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input and preparation stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[STG_IN])
        begin
            conc_reg  <= ice_concentration;
            depth_reg <= snow_depth;
            temp_reg  <= surface_temp;
        end
    end

    always_comb
    begin
        temp_exc    = {temp_reg[TEMP_W-1], temp_reg} + 17'sd256;
        warm        = temp_exc[TEMP_W] ? '0 : temp_exc[TEMP_W-1:0];
        // Round-half-up by an odd divisor reduces to a floor with a bias.
        y_ice_next  = YICE_W'(warm) * ICE_SLOPE + ICE_BIAS;
        y_snow_next = YSNOW_W'(warm) * SNOW_SLOPE + SNOW_BIAS;

        div_next[STG_PREP].zero = (conc_reg == '0) || (depth_reg == '0);
        div_next[STG_PREP].den  = {1'b0, depth_reg, 16'b0} + DEN_W'(conc_reg) * CONC_SCALE;
        div_next[STG_PREP].rem  = {depth_reg, 32'b0};
        div_next[STG_PREP].quo  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_PREP])
        begin
            y_ice_reg          <= y_ice_next;
            y_snow_reg         <= y_snow_next;
            div_reg[STG_PREP]  <= div_next[STG_PREP];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    for (genvar k = DIV_FIRST; k <= DIV_LAST; k++)
    begin : g_div
        localparam int B = DIV_LAST - k;
        logic [REM_W-1:0] shifted;

        always_comb
        begin
            shifted     = REM_W'(div_reg[k-1].den) << B;
            div_next[k] = div_reg[k-1];
            if (div_reg[k-1].rem >= shifted)
            begin
                div_next[k].rem    = div_reg[k-1].rem - shifted;
                div_next[k].quo[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Temperature branch, carried alongside the divider
    // ------------------------------------------------------------------
    assign ice_prod  = ICE_PROD_W'(y_ice_reg) * ICE_PROD_W'(ICE_RECIP);
    assign snow_prod = SNOW_PROD_W'(y_snow_reg) * SNOW_PROD_W'(SNOW_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[DIV_FIRST])
        begin
            ice_drop_reg  <= ice_prod[ICE_SHIFT +: DROP_W];
            snow_drop_reg <= snow_prod[SNOW_SHIFT +: DROP_W];
        end
    end

    assign ice_t_next  = $signed({5'b0, bare_ice_albedo_reg}) - $signed({1'b0, ice_drop_reg});
    assign snow_t_next = $signed({5'b0, snow_albedo_reg}) - $signed({1'b0, snow_drop_reg});

    always_ff @(posedge clk)
    begin
        if (en[STG_ALBT])
        begin
            ice_t_reg[STG_ALBT]  <= ice_t_next;
            snow_t_reg[STG_ALBT] <= snow_t_next;
        end
        for (int k = STG_ALBT + 1; k <= DIV_LAST; k++)
        begin
            if (en[k])
            begin
                ice_t_reg[k]  <= ice_t_reg[k-1];
                snow_t_reg[k] <= snow_t_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounding of the snow fraction and albedo difference
    // ------------------------------------------------------------------
    always_comb
    begin
        round_up  = {div_reg[DIV_LAST].rem[DEN_W-1:0], 1'b0} >= {1'b0, div_reg[DIV_LAST].den};
        frac_next = div_reg[DIV_LAST].zero
                  ? '0
                  : {1'b0, div_reg[DIV_LAST].quo} + FRAC_W'(round_up);
        diff_next = $signed({snow_t_reg[DIV_LAST][ALBT_W-1], snow_t_reg[DIV_LAST]})
                  - $signed({ice_t_reg[DIV_LAST][ALBT_W-1], ice_t_reg[DIV_LAST]});
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_ROUND])
        begin
            frac_reg    <= frac_next;
            diff_reg    <= diff_next;
            ice_rnd_reg <= ice_t_reg[DIV_LAST];
        end
    end

    // ------------------------------------------------------------------
    // Blend as ice + f * (snow - ice), and the transmitted fraction
    // ------------------------------------------------------------------
    assign blend_prod_next = BPROD_W'(diff_reg) * BPROD_W'($signed({1'b0, frac_reg}));
    assign pen_prod_next   = PPROD_W'(FRAC_ONE - frac_reg) * PPROD_W'(ice_transmissivity_reg);

    always_ff @(posedge clk)
    begin
        if (en[STG_MUL])
        begin
            blend_prod_reg <= blend_prod_next;
            pen_prod_reg   <= pen_prod_next;
            ice_mul_reg    <= ice_rnd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: round, saturate the albedo and hold the result word
    // ------------------------------------------------------------------
    always_comb
    begin
        // The rounding half is folded into the low bits of the ice term.
        blend_sum = $signed({blend_prod_reg[BPROD_W-1], blend_prod_reg})
                  + $signed({{4{ice_mul_reg[ALBT_W-1]}}, ice_mul_reg, 16'h8000});
        pen_sum   = pen_prod_reg + PPROD_W'(32768);

        if (blend_sum[SUM_W-1])
        begin
            albedo_next = '0;
        end
        else if (|blend_sum[SUM_W-2:16+FIELD_W])
        begin
            albedo_next = '1;
        end
        else
        begin
            albedo_next = blend_sum[16 +: FIELD_W];
        end
        pen_next = pen_sum[16 +: FIELD_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_OUT])
        begin
            albedo_reg <= albedo_next;
            pen_reg    <= pen_next;
        end
    end

    assign albedo         = albedo_reg;
    assign penetrating_sw = pen_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // With a nonzero concentration the quotient fits, so the final remainder is
    // below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DIV_LAST] && !div_reg[DIV_LAST].zero
        |-> div_reg[DIV_LAST].rem < REM_W'(div_reg[DIV_LAST].den))
        else $error("divider remainder not below divisor");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_ROUND] |-> frac_reg <= FRAC_ONE)
        else $error("snow fraction above one");

    a_hold_round: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_ROUND] && !en[STG_ROUND] |=> $stable(frac_reg) && valid_reg[STG_ROUND])
        else $error("held rounding stage changed");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[STG_IN] |-> !cell_stall)
        else $error("empty input stage stalls the sender");

endmodule
